// ----- sv/mutex_with_fifo_wait_queue_core_defines.svh -----
// Assertion macros for the mutex core.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef MUTEX_WITH_FIFO_WAIT_QUEUE_CORE_DEFINES_SVH
`define MUTEX_WITH_FIFO_WAIT_QUEUE_CORE_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define MWFQ_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: label");

// When the antecedent holds, the consequent must hold in the next cycle.
`define MWFQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ----- sv/mwfq_pkg.sv -----
// Shared types and constants for the mutex core with a FIFO wait queue.
// No dependencies; used by every module of the block.
package mwfq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS = 8;
   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_LOCK = 2'd0,
      KIND_TRY_LOCK = 2'd1,
      KIND_UNLOCK = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_ACQUIRED = 3'd0,
      STATUS_BUSY = 3'd1,
      STATUS_QUEUED = 3'd2,
      STATUS_RELEASED = 3'd3,
      STATUS_HANDOFF = 3'd4,
      STATUS_NOT_OWNER = 3'd5,
      STATUS_FULL = 3'd6
   } status_type;

   typedef enum logic {
      STATE_IDLE,
      STATE_EXEC
   } state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] requester_id;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] woken_id;
      logic [7:0] owner_id;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

// ----- sv/mutex_with_fifo_wait_queue_core.sv -----
// One hardware mutex with a FIFO of waiting requesters. A request (lock, try lock or unlock,
// tagged with a requester id, id 0 being the kernel) is accepted in the idle state and its result
// is loaded into the output register when the execute state commits it, so the input takes no new
// item until the previous one is committed; this step is set by the waiter queue memory, whose
// registered read of the oldest waiter is used in the execute state. A new item is accepted while
// the previous result still waits in the output register, but it then stays in the execute state,
// and the input stays closed, until that result is taken.
// The queue memory needs no clearing after reset.
module mutex_with_fifo_wait_queue_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mwfq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mwfq_pkg::rsp_type rsp_data
);

   mwfq_pkg::cmd_type  cmd;
   mwfq_pkg::stat_type stat;

   mwfq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mwfq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- sv/mwfq_ctrl.sv -----
// Controller state machine of the mutex core: accepts an item, then commits it.
// Depends on mwfq_pkg for the state, command and status types.
module mwfq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mwfq_pkg::stat_type stat,
   output mwfq_pkg::cmd_type  cmd
);

   mwfq_pkg::state_type state_ff;
   mwfq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mwfq_pkg::STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mwfq_pkg::STATE_IDLE: begin
            if (req_valid) begin
               state_in = mwfq_pkg::STATE_EXEC;
            end
         end
         mwfq_pkg::STATE_EXEC: begin
            if (stat.out_free) begin
               state_in = mwfq_pkg::STATE_IDLE;
            end
         end
         default: state_in = mwfq_pkg::STATE_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.load = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         mwfq_pkg::STATE_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         mwfq_pkg::STATE_EXEC: begin
            cmd.commit = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ----- sv/mwfq_dp.sv -----
// Datapath of the mutex core: lock state, waiter queue memory and result register.
// Depends on mwfq_pkg and on mutex_with_fifo_wait_queue_core_defines.svh.
`include "mutex_with_fifo_wait_queue_core_defines.svh"

module mwfq_dp (
   input  logic               clock,
   input  logic               reset,
   input  mwfq_pkg::req_type  req_data,
   input  mwfq_pkg::cmd_type  cmd,
   output mwfq_pkg::stat_type stat,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mwfq_pkg::rsp_type  rsp_data
);

   logic [mwfq_pkg::ID_BITS-1:0] waiters [mwfq_pkg::QUEUE_DEPTH];

   mwfq_pkg::req_type             req_ff;
   logic                          held_ff;
   logic                          held_in;
   logic [mwfq_pkg::ID_BITS-1:0]  owner_ff;
   logic [mwfq_pkg::ID_BITS-1:0]  owner_in;
   logic [mwfq_pkg::PTR_BITS-1:0] head_ptr_ff;
   logic [mwfq_pkg::PTR_BITS-1:0] tail_ptr_ff;
   logic [mwfq_pkg::CNT_BITS-1:0] count_ff;
   logic [mwfq_pkg::ID_BITS-1:0]  rd_data_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   mwfq_pkg::rsp_type             rsp_ff;

   logic [mwfq_pkg::ID_BITS-1:0]  id;
   logic [mwfq_pkg::ID_BITS-1:0]  woken;
   mwfq_pkg::status_type          status;
   logic                          do_push;
   logic                          do_pop;

   function automatic logic [mwfq_pkg::PTR_BITS-1:0] next_slot(
      input logic [mwfq_pkg::PTR_BITS-1:0] p
   );
      logic [mwfq_pkg::PTR_BITS-1:0] n;
      if (p == mwfq_pkg::PTR_BITS'(mwfq_pkg::QUEUE_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   assign id = mwfq_pkg::ID_BITS'(req_ff.requester_id);

   always_comb begin
      status = mwfq_pkg::STATUS_BUSY;
      woken = '0;
      held_in = held_ff;
      owner_in = owner_ff;
      do_push = 1'b0;
      do_pop = 1'b0;
      unique case (req_ff.kind) inside
         mwfq_pkg::KIND_LOCK, mwfq_pkg::KIND_TRY_LOCK: begin
            if (!held_ff) begin
               held_in = 1'b1;
               owner_in = id;
               status = mwfq_pkg::STATUS_ACQUIRED;
            end else if (req_ff.kind == mwfq_pkg::KIND_TRY_LOCK || id == '0) begin
               status = mwfq_pkg::STATUS_BUSY;
            end else if (count_ff == mwfq_pkg::CNT_BITS'(mwfq_pkg::QUEUE_DEPTH)) begin
               status = mwfq_pkg::STATUS_FULL;
            end else begin
               do_push = 1'b1;
               status = mwfq_pkg::STATUS_QUEUED;
            end
         end
         mwfq_pkg::KIND_UNLOCK: begin
            if (id != '0 && owner_ff != id) begin
               status = mwfq_pkg::STATUS_NOT_OWNER;
            end else if (count_ff != '0) begin
               do_pop = 1'b1;
               woken = rd_data_ff;
               held_in = 1'b1;
               owner_in = rd_data_ff;
               status = mwfq_pkg::STATUS_HANDOFF;
            end else begin
               held_in = 1'b0;
               owner_in = '0;
               status = mwfq_pkg::STATUS_RELEASED;
            end
         end
         default: status = mwfq_pkg::STATUS_BUSY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
         owner_ff <= '0;
         head_ptr_ff <= '0;
         tail_ptr_ff <= '0;
         count_ff <= '0;
      end else if (cmd.commit) begin
         held_ff <= held_in;
         owner_ff <= owner_in;
         if (do_push) begin
            tail_ptr_ff <= next_slot(tail_ptr_ff);
            count_ff <= count_ff + 1'b1;
         end
         if (do_pop) begin
            head_ptr_ff <= next_slot(head_ptr_ff);
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && do_push) begin
         waiters[tail_ptr_ff] <= id;
      end
      rd_data_ff <= waiters[head_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.commit) begin
         rsp_ff.status <= status;
         rsp_ff.woken_id <= 8'(woken);
         rsp_ff.owner_id <= 8'(owner_in);
      end
   end

   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.out_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `MWFQ_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= mwfq_pkg::CNT_BITS'(mwfq_pkg::QUEUE_DEPTH))
   `MWFQ_ASSERT_ALWAYS(a_free_is_empty, clock, reset, held_ff || (count_ff == '0 && owner_ff == '0))
   `MWFQ_ASSERT_NEXT(a_push_counts, clock, reset, cmd.commit && do_push, count_ff == $past(count_ff) + 1'b1)
   `MWFQ_ASSERT_NEXT(a_handoff_held, clock, reset, cmd.commit && do_pop, held_ff && rsp_valid_ff)

endmodule

// ----- tb/tb.sv -----
// Testbench for the mutex core with a FIFO wait queue: directed, backpressure and random tests.
// Expected results come from a predictor that is updated at each accepted request.
// Depends on mwfq_pkg and mutex_with_fifo_wait_queue_core.
`timescale 1ns / 1ps

module tb;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int RANDOM_ITEMS = 1750;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   mwfq_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   mwfq_pkg::rsp_type rsp_data;

   logic lock_held;
   logic [mwfq_pkg::ID_BITS-1:0] lock_owner;
   logic [mwfq_pkg::ID_BITS-1:0] waiting_ids[$];
   mwfq_pkg::rsp_type expected_rsp_q[$];

   bit idle_on;
   bit hold_off_request;
   int error_count;
   int cycle_count;

   mutex_with_fifo_wait_queue_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic mwfq_pkg::rsp_type apply_mutex_request(mwfq_pkg::req_type item);
      mwfq_pkg::rsp_type result;
      logic [mwfq_pkg::ID_BITS-1:0] id;
      id = item.requester_id;
      result.status = mwfq_pkg::STATUS_BUSY;
      result.woken_id = '0;
      case (item.kind) inside
         mwfq_pkg::KIND_LOCK, mwfq_pkg::KIND_TRY_LOCK: begin
            if (!lock_held) begin
               lock_held = 1'b1;
               lock_owner = id;
               result.status = mwfq_pkg::STATUS_ACQUIRED;
            end else if (item.kind == mwfq_pkg::KIND_TRY_LOCK || id == '0) begin
               result.status = mwfq_pkg::STATUS_BUSY;
            end else if (waiting_ids.size() >= mwfq_pkg::QUEUE_DEPTH) begin
               result.status = mwfq_pkg::STATUS_FULL;
            end else begin
               waiting_ids.push_back(id);
               result.status = mwfq_pkg::STATUS_QUEUED;
            end
         end
         mwfq_pkg::KIND_UNLOCK: begin
            if (id != '0 && lock_owner != id) begin
               result.status = mwfq_pkg::STATUS_NOT_OWNER;
            end else if (waiting_ids.size() > 0) begin
               result.woken_id = waiting_ids.pop_front();
               lock_held = 1'b1;
               lock_owner = result.woken_id;
               result.status = mwfq_pkg::STATUS_HANDOFF;
            end else begin
               lock_held = 1'b0;
               lock_owner = '0;
               result.status = mwfq_pkg::STATUS_RELEASED;
            end
         end
         default: begin
            result.status = mwfq_pkg::STATUS_BUSY;
         end
      endcase
      result.owner_id = lock_owner;
      return result;
   endfunction

   // Called just after an edge; returns just after the accepting edge or after an idle gap.
   task automatic send_request(logic [1:0] kind, logic [mwfq_pkg::ID_BITS-1:0] id);
      mwfq_pkg::req_type item;
      item.kind = kind;
      item.requester_id = id;
      req_data <= item;
      req_valid <= 1'b1;
      do
         @(posedge clock);
      while (!req_ready);
      expected_rsp_q.push_back(apply_mutex_request(item));
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   initial begin : rsp_side
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      mwfq_pkg::rsp_type expected;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected item: status %0d woken %0d owner %0d", $time,
               rsp_data.status, rsp_data.woken_id, rsp_data.owner_id);
            error_count++;
         end else begin
            expected = expected_rsp_q.pop_front();
            if (rsp_data.status !== expected.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                  expected.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.woken_id !== expected.woken_id) begin
               $display("%0t: woken_id expected %0d actual %0d", $time,
                  expected.woken_id, rsp_data.woken_id);
               error_count++;
            end
            if (rsp_data.owner_id !== expected.owner_id) begin
               $display("%0t: owner_id expected %0d actual %0d", $time,
                  expected.owner_id, rsp_data.owner_id);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic test_special_cases();
      send_request(mwfq_pkg::KIND_LOCK, 8'h00);
      send_request(mwfq_pkg::KIND_LOCK, 8'h00);
      send_request(mwfq_pkg::KIND_TRY_LOCK, 8'h55);
      send_request(KIND_UNUSED, 8'hAA);
      send_request(mwfq_pkg::KIND_LOCK, 8'h33);
      send_request(mwfq_pkg::KIND_UNLOCK, 8'h05);
      send_request(mwfq_pkg::KIND_UNLOCK, 8'h00);
      send_request(mwfq_pkg::KIND_UNLOCK, 8'h00);
      send_request(mwfq_pkg::KIND_UNLOCK, 8'hFF);
      send_request(mwfq_pkg::KIND_TRY_LOCK, 8'hFF);
      send_request(mwfq_pkg::KIND_LOCK, 8'hFF);
      send_request(mwfq_pkg::KIND_LOCK, 8'h01);
      send_request(mwfq_pkg::KIND_LOCK, 8'h80);
      send_request(mwfq_pkg::KIND_UNLOCK, 8'h01);
      send_request(mwfq_pkg::KIND_UNLOCK, 8'hFF);
      send_request(mwfq_pkg::KIND_UNLOCK, 8'hFF);
      send_request(mwfq_pkg::KIND_UNLOCK, 8'h00);
      send_request(mwfq_pkg::KIND_UNLOCK, 8'h80);
      send_request(mwfq_pkg::KIND_UNLOCK, 8'h80);
      send_request(KIND_UNUSED, 8'h00);
      send_request(mwfq_pkg::KIND_TRY_LOCK, 8'hAA);
      send_request(mwfq_pkg::KIND_UNLOCK, 8'hAA);
   endtask

   // The receiver holds off, so the input stalls, and more locks come than the queue holds.
   task automatic test_queue_full_backpressure();
      hold_off_request = 1'b1;
      send_request(mwfq_pkg::KIND_LOCK, 8'd1);
      for (int n = 2; n <= mwfq_pkg::QUEUE_DEPTH + 3; n++) begin
         send_request(mwfq_pkg::KIND_LOCK, n[mwfq_pkg::ID_BITS-1:0]);
      end
      for (int n = 0; n <= mwfq_pkg::QUEUE_DEPTH; n++) begin
         if (n % 3 == 0)
            send_request(mwfq_pkg::KIND_UNLOCK, 8'h00);
         else
            send_request(mwfq_pkg::KIND_UNLOCK, lock_owner);
      end
   endtask

   task automatic test_random_traffic(int count);
      int unsigned pick;
      int unsigned lock_share;
      logic [mwfq_pkg::ID_BITS-1:0] id;
      lock_share = 40;
      for (int n = 0; n < count; n++) begin
         if (n == count - count / 6)
            idle_on = 1'b0;
         if (n % 100 == 0)
            lock_share = $urandom_range(25, 70);
         if ($urandom_range(0, 3) == 0)
            id = mwfq_pkg::ID_BITS'($urandom_range(0, 255));
         else
            id = mwfq_pkg::ID_BITS'($urandom_range(1, 6));
         pick = $urandom_range(0, 99);
         if (pick < lock_share)
            send_request(mwfq_pkg::KIND_LOCK, id);
         else if (pick < lock_share + 8)
            send_request(mwfq_pkg::KIND_TRY_LOCK, id);
         else if (pick < 85)
            send_request(mwfq_pkg::KIND_UNLOCK, lock_owner);
         else if (pick < 90)
            send_request(mwfq_pkg::KIND_UNLOCK, 8'h00);
         else if (pick < 97)
            send_request(mwfq_pkg::KIND_UNLOCK, id);
         else
            send_request(KIND_UNUSED, id);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      lock_held = 1'b0;
      lock_owner = '0;
      idle_on = 1'b1;
      hold_off_request = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_special_cases();
      test_queue_full_backpressure();
      test_random_traffic(RANDOM_ITEMS);

      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
